@@ rtl/emr_pkg.sv @@
`timescale 1ns / 1ps

package emr_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgTicksPerUs = 2'd0;
  localparam logic [1:0] CfgTimeoutUs  = 2'd1;
  localparam logic [1:0] CfgMinCm      = 2'd2;
  localparam logic [1:0] CfgMaxCm      = 2'd3;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // Register values after reset
  localparam logic [7:0]  TicksPerUsRst = 8'd16;
  localparam logic [15:0] TimeoutUsRst  = 16'd30000;
  localparam logic [8:0]  MinCmRst      = 9'd2;
  localparam logic [8:0]  MaxCmRst      = 9'd400;

  // Timing and scaling constants
  localparam logic [15:0] TrigLowUs  = 16'd2;
  localparam logic [15:0] TrigHighUs = 16'd10;
  localparam logic [5:0]  UsPerCm    = 6'd58;
  localparam logic [8:0]  CmMax      = 9'd511;
  localparam logic [9:0]  ErrDist    = 10'd999;

  localparam int InDataW  = 8;
  localparam int OutDataW = 16;

  typedef struct packed {
    logic [7:0]  ticks_per_us;
    logic [15:0] timeout_us;
    logic [8:0]  min_cm;
    logic [8:0]  max_cm;
  } emr_cfg_t;

  typedef struct packed {
    logic       trigger_level;
    logic       busy_res;
    logic       done_res;
    logic [9:0] distance_cm;
    logic       error;
  } emr_res_t;

endpackage

@@ rtl/ultrasonic_echo_range_meter_top.sv @@
`timescale 1ns / 1ps

// Echo range meter for a trigger/echo ultrasonic sensor.
// Every input word is one sample tick: bit 0 requests a measurement (taken
// only while idle) and bit 1 is the sampled echo pin level. Every accepted
// word produces exactly one output word with the trigger pin level, a busy
// flag, and on the finishing tick the done flag, the distance in whole
// centimetres and the error flag (999 cm on timeout or out of range).
// The result of a word sits in the output register on the cycle after it is
// accepted. One word is taken per cycle unless the receiver stalls; the
// measurement state advances once per accepted word, so all timing is in
// accepted words, not raw clocks. Reset loads the default configuration,
// returns the meter to idle and empties the output register. When the receiver
// stalls, the output word holds, in_tready drops and the measurement state
// freezes until the word is taken. The user must write registers through
// cfg_we/cfg_idx/cfg_wdata only while idle; the block does not enforce it.
module ultrasonic_echo_range_meter_top import emr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // [0] start_req, [1] echo_level
  output logic                out_tvalid,
  input  logic                out_tready,
  // [0] trigger_level, [1] busy_res, [2] done_res, [12:3] distance_cm, [13] error
  output logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  emr_cfg_t cfg_r;
  emr_res_t res;
  emr_res_t out_res_r;
  logic     out_valid_r;
  logic     in_accept;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_us <= TicksPerUsRst;
      cfg_r.timeout_us   <= TimeoutUsRst;
      cfg_r.min_cm       <= MinCmRst;
      cfg_r.max_cm       <= MaxCmRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CfgTicksPerUs: cfg_r.ticks_per_us <= cfg_wdata[7:0];
        CfgTimeoutUs:  cfg_r.timeout_us   <= cfg_wdata[15:0];
        CfgMinCm:      cfg_r.min_cm       <= cfg_wdata[8:0];
        CfgMaxCm:      cfg_r.max_cm       <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  emr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_accept),
    .start_req  (in_tdata[0]),
    .echo_level (in_tdata[1]),
    .cfg        (cfg_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
    if (in_accept) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.error, out_res_r.distance_cm,
                       out_res_r.done_res, out_res_r.busy_res, out_res_r.trigger_level};

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.done_res && out_res_r.busy_res))
    else $error("done word still reports busy");

  a_err_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.error) |-> (out_res_r.done_res && out_res_r.distance_cm == ErrDist))
    else $error("error word without done or without error distance");

  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.trigger_level) |-> out_res_r.busy_res)
    else $error("trigger high while idle");

  a_idle_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.done_res) |-> (out_res_r.distance_cm == 10'd0))
    else $error("distance reported without done");

endmodule

@@ rtl/emr_core.sv @@
`timescale 1ns / 1ps

module emr_core import emr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  logic     start_req,
  input  logic     echo_level,
  input  emr_cfg_t cfg,
  output emr_res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_RISE = 3'd3,
    PH_MEASURE   = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  pc_r, pc_nxt;
  logic [15:0] phase_us_r, phase_us_nxt;
  logic [5:0]  cm_sub_r, cm_sub_nxt;
  logic [8:0]  cm_r, cm_nxt;

  logic [7:0]  tpu;
  logic [8:0]  pc_inc;
  logic        us_tick;
  logic [7:0]  pc_adv;
  logic [16:0] us_inc;
  logic        timeout_hit;
  logic [5:0]  sub_inc;
  logic        done;
  logic        err;
  logic [9:0]  dist_cm;

  always_comb begin
    // A rate of zero ticks per microsecond behaves as one.
    tpu         = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;
    pc_inc      = {1'b0, pc_r} + 9'd1;
    us_tick     = pc_inc >= {1'b0, tpu};
    pc_adv      = us_tick ? 8'd0 : pc_inc[7:0];
    us_inc      = {1'b0, phase_us_r} + 17'd1;
    timeout_hit = us_inc >= {1'b0, cfg.timeout_us};
    sub_inc     = cm_sub_r + 6'd1;

    phase_nxt    = phase_r;
    pc_nxt       = pc_r;
    phase_us_nxt = phase_us_r;
    cm_sub_nxt   = cm_sub_r;
    cm_nxt       = cm_r;
    done         = 1'b0;
    err          = 1'b0;
    dist_cm      = 10'd0;

    unique case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          phase_nxt    = PH_TRIG_LOW;
          pc_nxt       = 8'd0;
          phase_us_nxt = 16'd0;
        end
      end
      PH_TRIG_LOW, PH_TRIG_HIGH: begin
        pc_nxt = pc_adv;
        if (us_tick) begin
          phase_us_nxt = us_inc[15:0];
          if (us_inc[15:0] >= ((phase_r == PH_TRIG_LOW) ? TrigLowUs : TrigHighUs)) begin
            phase_nxt    = (phase_r == PH_TRIG_LOW) ? PH_TRIG_HIGH : PH_WAIT_RISE;
            phase_us_nxt = 16'd0;
          end
        end
      end
      PH_WAIT_RISE: begin
        if (echo_level) begin
          phase_nxt    = PH_MEASURE;
          pc_nxt       = 8'd0;
          phase_us_nxt = 16'd0;
          cm_sub_nxt   = 6'd0;
          cm_nxt       = 9'd0;
        end else begin
          pc_nxt = pc_adv;
          if (us_tick) begin
            if (timeout_hit) begin
              done = 1'b1;
              err  = 1'b1;
            end
            phase_us_nxt = us_inc[15:0];
          end
        end
      end
      PH_MEASURE: begin
        pc_nxt = pc_adv;
        if (us_tick) begin
          if (sub_inc >= UsPerCm) begin
            cm_sub_nxt = 6'd0;
            if (cm_r < CmMax) cm_nxt = cm_r + 9'd1;
          end else begin
            cm_sub_nxt = sub_inc;
          end
        end
        if (!echo_level) begin
          // The distance includes the microsecond that may end on this tick.
          done    = 1'b1;
          dist_cm = {1'b0, cm_nxt};
          if (cm_nxt < cfg.min_cm || cm_nxt > cfg.max_cm) err = 1'b1;
        end else if (us_tick) begin
          if (timeout_hit) begin
            done = 1'b1;
            err  = 1'b1;
          end
          phase_us_nxt = us_inc[15:0];
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase

    if (done) phase_nxt = PH_IDLE;

    res.trigger_level = (phase_nxt == PH_TRIG_HIGH);
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.done_res      = done;
    res.distance_cm   = (done && err) ? ErrDist : dist_cm;
    res.error         = done && err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pc_r       <= 8'd0;
      phase_us_r <= 16'd0;
      cm_sub_r   <= 6'd0;
      cm_r       <= 9'd0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      pc_r       <= pc_nxt;
      phase_us_r <= phase_us_nxt;
      cm_sub_r   <= cm_sub_nxt;
      cm_r       <= cm_nxt;
    end
  end

endmodule
